FILE: rtl/apt_pkg.sv
package apt_pkg;

  localparam int MAX_RES_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DIR_W        = 16;
  localparam int SIZE_W       = 13;
  localparam int COORD_W      = 12;
  localparam int INDEX_W      = 24;
  localparam int RAD_W        = 32;
  localparam int ROOT_W       = 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROBE_WIDTH  = 2'd0,
    REG_PROBE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [COORD_W-1:0] texel_column;
    logic [COORD_W-1:0] texel_row;
    logic [INDEX_W-1:0] texel_index;
  } texel_t;

  // Arctangent of 2^-i in half turns, Q31.
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // A size register of zero acts as one; values above the maximum saturate.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r,
                                                 input int max_res);
    logic [SIZE_W-1:0] res;
    if (r == '0) begin
      res = SIZE_W'(1);
    end else if (int'(r) > max_res) begin
      res = SIZE_W'(max_res);
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

FILE: rtl/apt_isqrt.sv
module apt_isqrt import apt_pkg::*; #(
  parameter int SIDE_W = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [1:0][RAD_W-1:0]  rad,
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   out_valid,
  output logic [1:0][ROOT_W-1:0] root,
  output logic [SIDE_W-1:0]      side_out
);

  // Two floor square roots side by side, one result bit per stage.
  localparam int STEPS = ROOT_W;
  localparam int REM_W = ROOT_W + 4;

  logic              v_q    [STEPS];
  logic [RAD_W-1:0]  n_q    [STEPS][2];
  logic [REM_W-1:0]  rem_q  [STEPS][2];
  logic [ROOT_W-1:0] root_q [STEPS][2];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    localparam int J = STEPS - 1 - k;
    logic              v_c;
    logic [SIDE_W-1:0] side_c;

    if (k == 0) begin : g_ctl
      assign v_c    = in_valid;
      assign side_c = side_in;
    end else begin : g_ctl
      assign v_c    = v_q[k-1];
      assign side_c = side_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k] <= side_c;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RAD_W-1:0]  n_c;
      logic [REM_W-1:0]  rem_c;
      logic [ROOT_W-1:0] root_c;
      logic [REM_W-1:0]  sh;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_src
        assign n_c    = rad[l];
        assign rem_c  = '0;
        assign root_c = '0;
      end else begin : g_src
        assign n_c    = n_q[k-1][l];
        assign rem_c  = rem_q[k-1][l];
        assign root_c = root_q[k-1][l];
      end

      assign sh    = {rem_c[REM_W-3:0], n_c[2*J+1 -: 2]};
      assign trial = (REM_W'(root_c) << 2) | REM_W'(1);
      assign ge    = (sh >= trial);

      always_ff @(posedge clk) begin
        if (en) begin
          n_q[k][l]    <= n_c;
          rem_q[k][l]  <= ge ? (sh - trial) : sh;
          root_q[k][l] <= {root_c[ROOT_W-2:0], ge};
        end
      end
    end
  end

  assign out_valid = v_q[STEPS-1];
  assign root[0]   = root_q[STEPS-1][0];
  assign root[1]   = root_q[STEPS-1][1];
  assign side_out  = side_q[STEPS-1];

endmodule

FILE: rtl/apt_cordic.sv
module apt_cordic import apt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [DIR_W-1:0] z,
  input  logic [ROOT_W-1:0]       s,
  input  logic [SIDE_W-1:0]       side_in,
  output logic                    out_valid,
  output logic [FRAC_BITS:0]      ang,
  output logic [SIDE_W-1:0]       side_out
);

  // Vectoring CORDIC on (z, s); the accumulated angle is acos(z) in half turns.
  localparam int VW    = 34;
  localparam int STEPS = CORDIC_STEPS;
  localparam logic signed [VW-1:0] ACC_MAX = {{(VW-32){1'b0}}, 32'h8000_0000};
  localparam logic signed [VW-1:0] ACC_HALF = {{(VW-32){1'b0}}, 32'h4000_0000};

  logic                 v_q    [STEPS+1];
  logic signed [VW-1:0] vx_q   [STEPS+1];
  logic signed [VW-1:0] vy_q   [STEPS+1];
  logic signed [VW-1:0] acc_q  [STEPS+1];
  logic [SIDE_W-1:0]    side_q [STEPS+1];

  logic signed [VW-1:0] zx;
  logic signed [VW-1:0] sx;

  assign zx = VW'(z) <<< 14;
  assign sx = VW'(s) << 14;

  // Entry stage: a negative z is first turned by a quarter turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_in;
      if (z[DIR_W-1]) begin
        vx_q[0]  <= sx;
        vy_q[0]  <= -zx;
        acc_q[0] <= ACC_HALF;
      end else begin
        vx_q[0]  <= zx;
        vy_q[0]  <= sx;
        acc_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [VW-1:0] tab;

    assign dx  = vy_q[i] >>> i;
    assign dy  = vx_q[i] >>> i;
    assign tab = {{(VW-32){1'b0}}, ATAN_TAB[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else if (en) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[i+1] <= side_q[i];
        if (vy_q[i] > 0) begin
          vx_q[i+1]  <= vx_q[i] + dx;
          vy_q[i+1]  <= vy_q[i] - dy;
          acc_q[i+1] <= acc_q[i] + tab;
        end else begin
          vx_q[i+1]  <= vx_q[i] - dx;
          vy_q[i+1]  <= vy_q[i] + dy;
          acc_q[i+1] <= acc_q[i] - tab;
        end
      end
    end
  end

  logic [31:0] acc_c;

  always_comb begin
    if (acc_q[STEPS] < 0) begin
      acc_c = '0;
    end else if (acc_q[STEPS] > ACC_MAX) begin
      acc_c = 32'h8000_0000;
    end else begin
      acc_c = acc_q[STEPS][31:0];
    end
  end

  assign out_valid = v_q[STEPS];
  assign ang       = acc_c[31 -: FRAC_BITS+1];
  assign side_out  = side_q[STEPS];

endmodule

FILE: rtl/apt_div.sv
module apt_div import apt_pkg::*; #(
  parameter int DVD_W  = 46,
  parameter int DEN_W  = 33,
  parameter int QW     = 13,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [1:0][DVD_W-1:0] dvd,
  input  logic [DEN_W-1:0]      den,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [1:0][QW-1:0]    quo,
  output logic [SIDE_W-1:0]     side_out
);

  // Restoring division of two dividends by one divisor, one quotient bit per
  // stage. The quotient is known to fit in QW bits.
  logic              v_q    [QW];
  logic [DEN_W-1:0]  den_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];
  logic [DVD_W-1:0]  rem_q  [QW][2];
  logic [QW-1:0]     q_q    [QW][2];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic              v_c;
    logic [DEN_W-1:0]  den_c;
    logic [SIDE_W-1:0] side_c;
    logic [DVD_W-1:0]  sub;

    if (k == 0) begin : g_ctl
      assign v_c    = in_valid;
      assign den_c  = den;
      assign side_c = side_in;
    end else begin : g_ctl
      assign v_c    = v_q[k-1];
      assign den_c  = den_q[k-1];
      assign side_c = side_q[k-1];
    end

    assign sub = DVD_W'(den_c) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k]  <= den_c;
        side_q[k] <= side_c;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DVD_W-1:0] rem_c;
      logic [QW-1:0]    q_c;
      logic             ge;

      if (k == 0) begin : g_src
        assign rem_c = dvd[l];
        assign q_c   = '0;
      end else begin : g_src
        assign rem_c = rem_q[k-1][l];
        assign q_c   = q_q[k-1][l];
      end

      assign ge = (rem_c >= sub);

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k][l] <= ge ? (rem_c - sub) : rem_c;
          q_q[k][l]   <= {q_c[QW-2:0], ge};
        end
      end
    end
  end

  assign out_valid = v_q[QW-1];
  assign quo[0]    = q_q[QW-1][0];
  assign quo[1]    = q_q[QW-1][1];
  assign side_out  = side_q[QW-1];

endmodule

FILE: rtl/angular_probe_texel_address_unit.sv
// Channel  Direction  Handshake              Payload
// dir      in         dir_valid / dir_ready  dir_t: dir_x, dir_y, dir_z (Q1.15)
// texel    out        texel_valid/texel_ready texel_t: column, row, index
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One direction is taken per cycle while the skid register is empty (dir_ready
// high). A direction's path to texel holds 66 register stages: the square root
// pipeline (16), the CORDIC arctangent pipeline (31), the divider (13) and six
// single stages.
// Reset (rst, synchronous) clears all valid bits and loads both probe sizes
// with 1024. cfg_ready is always high.
// A stalled result sits in the output register; the next one goes to a skid
// register and the whole pipeline holds while that register is full.
module angular_probe_texel_address_unit import apt_pkg::*; #(
  parameter int MAX_RES   = MAX_RES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  dir_valid,
  output logic                  dir_ready,
  input  dir_t                  dir,
  output logic                  texel_valid,
  input  logic                  texel_ready,
  output texel_t                texel,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Numerator a*c + rho*2^F is non-negative and below 2^(F+17).
  localparam int NUM_W  = FRAC_BITS + 17;
  localparam int PROD_W = FRAC_BITS + 19;
  localparam int DVD_W  = NUM_W + SIZE_W;
  localparam int DEN_W  = ROOT_W + FRAC_BITS + 1;
  localparam int IDX_W  = 2 * SIZE_W + 1;

  typedef struct packed {
    logic signed [DIR_W-1:0] x;
    logic signed [DIR_W-1:0] y;
    logic [ROOT_W-1:0]       rho;
  } plane_t;

  // Configuration registers. Writes are to happen only while the block is idle, so
  // every stage reads the live values; the user must ensure this, the block does not enforce it.
  logic [SIZE_W-1:0] probe_width;
  logic [SIZE_W-1:0] probe_height;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_width  <= SIZE_RESET;
      probe_height <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROBE_WIDTH:  probe_width  <= cfg_data[SIZE_W-1:0];
        REG_PROBE_HEIGHT: probe_height <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = eff_size(probe_width, MAX_RES);
  assign h_eff = eff_size(probe_height, MAX_RES);

  // The pipeline advances as a whole unless the skid register holds a result.
  logic   en;
  logic   skid_valid;
  texel_t skid_texel;

  assign en        = !skid_valid;
  assign dir_ready = en;

  // Stage 0: squares. Lane 0 gets x*x + y*y, lane 1 gets 1 - z*z (Q30).
  logic signed [2*DIR_W-1:0] xx;
  logic signed [2*DIR_W-1:0] yy;
  logic signed [2*DIR_W-1:0] zz;
  logic                      p0_valid;
  dir_t                      p0_dir;
  logic [1:0][RAD_W-1:0]     p0_rad;

  assign xx = dir.dir_x * dir.dir_x;
  assign yy = dir.dir_y * dir.dir_y;
  assign zz = dir.dir_z * dir.dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (en) begin
      p0_valid <= dir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_dir    <= dir;
      p0_rad[0] <= RAD_W'(xx) + RAD_W'(yy);
      p0_rad[1] <= (RAD_W'(1) << 30) - RAD_W'(zz);
    end
  end

  // Square roots: rho = |(x, y)| and s = sin of the polar angle, both Q15.
  logic                   sq_valid;
  logic [1:0][ROOT_W-1:0] sq_root;
  dir_t                   sq_dir;

  apt_isqrt #(
    .SIDE_W ($bits(dir_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p0_valid),
    .rad       (p0_rad),
    .side_in   (p0_dir),
    .out_valid (sq_valid),
    .root      (sq_root),
    .side_out  (sq_dir)
  );

  // Polar angle over pi in Q.FRAC_BITS.
  plane_t               sq_plane;
  logic                 cd_valid;
  logic [FRAC_BITS:0]   cd_ang;
  plane_t               cd_plane;

  assign sq_plane.x   = sq_dir.dir_x;
  assign sq_plane.y   = sq_dir.dir_y;
  assign sq_plane.rho = sq_root[0];

  apt_cordic #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    ($bits(plane_t))
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .z         (sq_dir.dir_z),
    .s         (sq_root[1]),
    .side_in   (sq_plane),
    .out_valid (cd_valid),
    .ang       (cd_ang),
    .side_out  (cd_plane)
  );

  // Stage p1: numerators a*x + rho*2^F and a*(-y) + rho*2^F.
  logic signed [FRAC_BITS+1:0] a_s;
  logic signed [DIR_W:0]       xc;
  logic signed [DIR_W:0]       yc;
  logic signed [PROD_W-1:0]    prod_c;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [PROD_W-1:0]    rho_t;
  logic                        p1_valid;
  logic [1:0][NUM_W-1:0]       p1_num;
  logic [ROOT_W-1:0]           p1_rho;

  assign a_s    = {1'b0, cd_ang};
  assign xc     = (DIR_W+1)'(cd_plane.x);
  assign yc     = -((DIR_W+1)'(cd_plane.y));
  assign prod_c = a_s * xc;
  assign prod_r = a_s * yc;
  assign rho_t  = PROD_W'(cd_plane.rho) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_num[0] <= NUM_W'(prod_c + rho_t);
      p1_num[1] <= NUM_W'(prod_r + rho_t);
      p1_rho    <= cd_plane.rho;
    end
  end

  // Stage p2: scale by the probe size and form the divisor rho*2^(F+1).
  logic                  p2_valid;
  logic [1:0][DVD_W-1:0] p2_dvd;
  logic [DEN_W-1:0]      p2_den;
  logic                  p2_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_dvd[0] <= DVD_W'(w_eff) * DVD_W'(p1_num[0]);
      p2_dvd[1] <= DVD_W'(h_eff) * DVD_W'(p1_num[1]);
      p2_den    <= DEN_W'(p1_rho) << (FRAC_BITS + 1);
      p2_zero   <= (p1_rho == '0);
    end
  end

  logic                   dv_valid;
  logic [1:0][SIZE_W-1:0] dv_quo;
  logic                   dv_zero;

  apt_div #(
    .DVD_W  (DVD_W),
    .DEN_W  (DEN_W),
    .QW     (SIZE_W),
    .SIDE_W (1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p2_valid),
    .dvd       (p2_dvd),
    .den       (p2_den),
    .side_in   (p2_zero),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .side_out  (dv_zero)
  );

  // Stage p3: clamp to the far edge; a direction on the z axis maps to the
  // centre texel, where the divisor was zero.
  logic              p3_valid;
  logic [SIZE_W-1:0] p3_col;
  logic [SIZE_W-1:0] p3_row;
  logic [SIZE_W-1:0] col_next;
  logic [SIZE_W-1:0] row_next;

  always_comb begin
    if (dv_zero) begin
      col_next = w_eff >> 1;
      row_next = h_eff >> 1;
    end else begin
      col_next = (dv_quo[0] >= w_eff) ? (w_eff - SIZE_W'(1)) : dv_quo[0];
      row_next = (dv_quo[1] >= h_eff) ? (h_eff - SIZE_W'(1)) : dv_quo[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_col <= col_next;
      p3_row <= row_next;
    end
  end

  // Stage p4: linear index.
  logic   p4_valid;
  texel_t p4_texel;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (en) begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_texel.texel_column <= p3_col[COORD_W-1:0];
      p4_texel.texel_row    <= p3_row[COORD_W-1:0];
      p4_texel.texel_index  <= INDEX_W'(IDX_W'(p3_col) + IDX_W'(p3_row) * IDX_W'(w_eff));
    end
  end

  // Output register with a skid register behind it. While the skid register
  // is empty the pipeline moves and its tail lands in whichever is free.
  logic out_free;

  assign out_free = !texel_valid || texel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      texel_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        texel_valid <= 1'b1;
        skid_valid  <= 1'b0;
      end
    end else if (out_free) begin
      texel_valid <= p4_valid;
    end else if (p4_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        texel <= skid_texel;
      end
    end else if (out_free) begin
      texel <= p4_texel;
    end else begin
      skid_texel <= p4_texel;
    end
  end

endmodule

FILE: rtl/apt_checker.sv
module apt_checker import apt_pkg::*; #(
  parameter int MAX_RES = MAX_RES_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  dir_ready,
  input logic                  texel_valid,
  input logic                  texel_ready,
  input texel_t                texel,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] width_seen;
  logic [SIZE_W-1:0] height_seen;
  logic [SIZE_W-1:0] w_chk;
  logic [SIZE_W-1:0] h_chk;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_seen  <= SIZE_RESET;
      height_seen <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROBE_WIDTH:  width_seen  <= cfg_data[SIZE_W-1:0];
        REG_PROBE_HEIGHT: height_seen <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_chk = eff_size(width_seen, MAX_RES);
  assign h_chk = eff_size(height_seen, MAX_RES);

  a_reset_empty: assert property (@(posedge clk) rst |=> !texel_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    texel_valid && !texel_ready |=> texel_valid && $stable(texel))
    else $error("stalled result changed");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    texel_valid |-> ({1'b0, texel.texel_column} < w_chk) &&
                    ({1'b0, texel.texel_row} < h_chk))
    else $error("texel outside the probe");

  a_index: assert property (@(posedge clk) disable iff (rst)
    texel_valid && (w_chk <= SIZE_W'(4096)) && (h_chk <= SIZE_W'(4096)) |->
      texel.texel_index == INDEX_W'(27'(texel.texel_column) +
                                    27'(texel.texel_row) * 27'(w_chk)))
    else $error("linear index does not match column and row");

  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(dir_ready) |-> $past(texel_valid && !texel_ready))
    else $error("input stalled without an output stall");

endmodule

bind angular_probe_texel_address_unit apt_checker #(.MAX_RES(MAX_RES)) u_apt_checker (.*);
